[sv/ddipd_pkg.sv]
// shared types, widths and reset values for the differential drive pd controller
package ddipd_pkg;

    localparam int DATA_W    = 16;
    localparam int ERR_W     = DATA_W + 1;
    localparam int RAW_W     = 34;
    localparam int TERM_W    = RAW_W - DATA_W;
    localparam int DUTY_W    = 32;
    localparam int SUM_W     = 34;
    localparam int MIR_W     = DATA_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 8 * DATA_W;
    localparam int M_TDATA_W = 2 * DUTY_W + 2 * DATA_W;

    localparam logic signed [DATA_W-1:0] KP_LINEAR_RST    = 16'sd256;
    localparam logic signed [DATA_W-1:0] KD_LINEAR_RST    = 16'sd0;
    localparam logic signed [DATA_W-1:0] KP_ANGULAR_RST   = 16'sd256;
    localparam logic signed [DATA_W-1:0] KD_ANGULAR_RST   = 16'sd0;
    localparam logic [DATA_W-1:0]        DUTY_MAX_RST     = 16'd2000;
    localparam logic [DATA_W-1:0]        DUTY_MIN_RST     = 16'd1000;
    localparam logic [DATA_W-1:0]        DUTY_NEUTRAL_RST = 16'd1500;
    localparam logic signed [DUTY_W-1:0] DUTY_STATE_RST   = 32'sd1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_LINEAR    = 3'd0,
        REG_KD_LINEAR    = 3'd1,
        REG_KP_ANGULAR   = 3'd2,
        REG_KD_ANGULAR   = 3'd3,
        REG_DUTY_MAX     = 3'd4,
        REG_DUTY_MIN     = 3'd5,
        REG_DUTY_NEUTRAL = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] kp_linear;
        logic signed [DATA_W-1:0] kd_linear;
        logic signed [DATA_W-1:0] kp_angular;
        logic signed [DATA_W-1:0] kd_angular;
        logic [DATA_W-1:0]        duty_max;
        logic [DATA_W-1:0]        duty_min;
        logic [DATA_W-1:0]        duty_neutral;
    } cfg_t;

    // load enables for the two pipeline stages inside a pd term unit
    typedef struct packed {
        logic ld_raw;
        logic ld_term;
    } pd_ctl_t;

endpackage

[sv/ddipd_cfg.sv]
// configuration register file: gains and duty limits
module ddipd_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [ddipd_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [ddipd_pkg::DATA_W-1:0]         wr_data,
    output ddipd_pkg::cfg_t                      cfg
);

    ddipd_pkg::cfg_t cfg_reg;
    ddipd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (ddipd_pkg::reg_idx_t'(wr_index))
                ddipd_pkg::REG_KP_LINEAR:    cfg_next.kp_linear    = wr_data;
                ddipd_pkg::REG_KD_LINEAR:    cfg_next.kd_linear    = wr_data;
                ddipd_pkg::REG_KP_ANGULAR:   cfg_next.kp_angular   = wr_data;
                ddipd_pkg::REG_KD_ANGULAR:   cfg_next.kd_angular   = wr_data;
                ddipd_pkg::REG_DUTY_MAX:     cfg_next.duty_max     = wr_data;
                ddipd_pkg::REG_DUTY_MIN:     cfg_next.duty_min     = wr_data;
                ddipd_pkg::REG_DUTY_NEUTRAL: cfg_next.duty_neutral = wr_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_linear    <= ddipd_pkg::KP_LINEAR_RST;
            cfg_reg.kd_linear    <= ddipd_pkg::KD_LINEAR_RST;
            cfg_reg.kp_angular   <= ddipd_pkg::KP_ANGULAR_RST;
            cfg_reg.kd_angular   <= ddipd_pkg::KD_ANGULAR_RST;
            cfg_reg.duty_max     <= ddipd_pkg::DUTY_MAX_RST;
            cfg_reg.duty_min     <= ddipd_pkg::DUTY_MIN_RST;
            cfg_reg.duty_neutral <= ddipd_pkg::DUTY_NEUTRAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/ddipd_pd_term.sv]
// one pd term: kp*(target-measured) - kd*accel, then q16.16 product scaled down toward zero
module ddipd_pd_term
(
    input  logic                                  clk,
    input  ddipd_pkg::pd_ctl_t                    ctl,
    input  logic signed [ddipd_pkg::DATA_W-1:0]   kp,
    input  logic signed [ddipd_pkg::DATA_W-1:0]   kd,
    input  logic signed [ddipd_pkg::DATA_W-1:0]   target,
    input  logic signed [ddipd_pkg::DATA_W-1:0]   measured,
    input  logic signed [ddipd_pkg::DATA_W-1:0]   accel,
    output logic signed [ddipd_pkg::TERM_W-1:0]   term
);

    localparam int ERR_W  = ddipd_pkg::ERR_W;
    localparam int RAW_W  = ddipd_pkg::RAW_W;
    localparam int PROD_P_W = ddipd_pkg::DATA_W + ERR_W;
    localparam int PROD_D_W = 2 * ddipd_pkg::DATA_W;
    localparam int FRAC_W = ddipd_pkg::DATA_W;

    logic signed [ERR_W-1:0]    err;
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_D_W-1:0] prod_d;
    logic signed [RAW_W-1:0]    raw_next;
    logic signed [RAW_W-1:0]    raw_reg;
    logic signed [RAW_W-1:0]    raw_adj;
    logic signed [ddipd_pkg::TERM_W-1:0] term_next;
    logic signed [ddipd_pkg::TERM_W-1:0] term_reg;

    assign err      = ERR_W'(target) - ERR_W'(measured);
    assign prod_p   = PROD_P_W'(kp) * PROD_P_W'(err);
    assign prod_d   = PROD_D_W'(kd) * PROD_D_W'(accel);
    assign raw_next = RAW_W'(prod_p) - RAW_W'(prod_d);

    // bias negative values by one lsb less than the divisor so the shift truncates toward zero
    assign raw_adj   = raw_reg + (raw_reg[RAW_W-1] ? RAW_W'((1 << FRAC_W) - 1) : RAW_W'(0));
    assign term_next = raw_adj[RAW_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (ctl.ld_raw)
        begin
            raw_reg <= raw_next;
        end
        if (ctl.ld_term)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

[sv/ddipd_accum.sv]
// duty accumulators: add pd terms, saturate, clamp, mirror and register the result
module ddipd_accum
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ddipd_pkg::cfg_t                       cfg,
    input  logic                                  ld,
    input  logic signed [ddipd_pkg::TERM_W-1:0]   lin_l,
    input  logic signed [ddipd_pkg::TERM_W-1:0]   lin_r,
    input  logic signed [ddipd_pkg::TERM_W-1:0]   ang,
    input  logic                                  manual,
    output logic signed [ddipd_pkg::DUTY_W-1:0]   left_sum,
    output logic signed [ddipd_pkg::DUTY_W-1:0]   right_sum,
    output logic [ddipd_pkg::DATA_W-1:0]          left_compare,
    output logic [ddipd_pkg::DATA_W-1:0]          right_compare,
    output logic                                  drive_valid
);

    localparam int DUTY_W = ddipd_pkg::DUTY_W;
    localparam int SUM_W  = ddipd_pkg::SUM_W;
    localparam int DATA_W = ddipd_pkg::DATA_W;
    localparam int MIR_W  = ddipd_pkg::MIR_W;
    localparam int CMP_W  = DUTY_W + 1;

    logic signed [DUTY_W-1:0] left_duty_reg;
    logic signed [DUTY_W-1:0] right_duty_reg;
    logic signed [DUTY_W-1:0] left_duty_next;
    logic signed [DUTY_W-1:0] right_duty_next;

    logic signed [SUM_W-1:0]  sum_l;
    logic signed [SUM_W-1:0]  sum_r;
    logic signed [DUTY_W-1:0] sat_l;
    logic signed [DUTY_W-1:0] sat_r;
    logic [DATA_W-1:0]        clamp_l;
    logic [DATA_W-1:0]        clamp_r;
    logic signed [MIR_W-1:0]  mir;
    logic [DATA_W-1:0]        mir_sat;

    logic signed [DUTY_W-1:0] left_sum_reg;
    logic signed [DUTY_W-1:0] right_sum_reg;
    logic [DATA_W-1:0]        left_cmp_reg;
    logic [DATA_W-1:0]        right_cmp_reg;
    logic                     drive_valid_reg;
    logic [DATA_W-1:0]        left_cmp_next;
    logic [DATA_W-1:0]        right_cmp_next;

    function automatic logic signed [DUTY_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [DUTY_W-1:0] r;
        if (v[SUM_W-1:DUTY_W-1] == '0 || v[SUM_W-1:DUTY_W-1] == '1)
        begin
            r = v[DUTY_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(DUTY_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DUTY_W-1){1'b1}}};
        end
        return r;
    endfunction

    // min tested first and also taken whenever max is below min, so min wins when the limits cross
    function automatic logic [DATA_W-1:0] clamp_duty(input logic signed [DUTY_W-1:0] v,
                                                     input logic [DATA_W-1:0] hi,
                                                     input logic [DATA_W-1:0] lo);
        logic signed [CMP_W-1:0] v_ext;
        logic signed [CMP_W-1:0] hi_ext;
        logic signed [CMP_W-1:0] lo_ext;
        logic [DATA_W-1:0]       r;
        v_ext  = CMP_W'(v);
        hi_ext = CMP_W'(hi);
        lo_ext = CMP_W'(lo);
        if (v_ext < lo_ext || hi < lo)
        begin
            r = lo;
        end
        else if (v_ext > hi_ext)
        begin
            r = hi;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    assign sum_l = SUM_W'(left_duty_reg) + SUM_W'(lin_l) - SUM_W'(ang);
    assign sum_r = SUM_W'(right_duty_reg) + SUM_W'(lin_r) + SUM_W'(ang);
    assign sat_l = sat32(sum_l);
    assign sat_r = sat32(sum_r);

    assign clamp_l = clamp_duty(sat_l, cfg.duty_max, cfg.duty_min);
    assign clamp_r = clamp_duty(sat_r, cfg.duty_max, cfg.duty_min);

    // right side mirrored about neutral, held to the 16 bit compare range
    assign mir = {1'b0, cfg.duty_neutral, 1'b0} - MIR_W'({1'b0, clamp_r});

    always_comb
    begin
        if (mir[MIR_W-1])
        begin
            mir_sat = '0;
        end
        else if (mir[MIR_W-2])
        begin
            mir_sat = '1;
        end
        else
        begin
            mir_sat = mir[DATA_W-1:0];
        end
    end

    always_comb
    begin
        if (manual)
        begin
            left_duty_next  = DUTY_W'(cfg.duty_neutral);
            right_duty_next = DUTY_W'(cfg.duty_neutral);
            left_cmp_next   = '0;
            right_cmp_next  = '0;
        end
        else
        begin
            left_duty_next  = DUTY_W'(clamp_l);
            right_duty_next = DUTY_W'(clamp_r);
            left_cmp_next   = clamp_l;
            right_cmp_next  = mir_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_duty_reg  <= ddipd_pkg::DUTY_STATE_RST;
            right_duty_reg <= ddipd_pkg::DUTY_STATE_RST;
        end
        else if (ld)
        begin
            left_duty_reg  <= left_duty_next;
            right_duty_reg <= right_duty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            left_sum_reg    <= sat_l;
            right_sum_reg   <= sat_r;
            left_cmp_reg    <= left_cmp_next;
            right_cmp_reg   <= right_cmp_next;
            drive_valid_reg <= ~manual;
        end
    end

    assign left_sum      = left_sum_reg;
    assign right_sum     = right_sum_reg;
    assign left_compare  = left_cmp_reg;
    assign right_compare = right_cmp_reg;
    assign drive_valid   = drive_valid_reg;

endmodule

[sv/diff_drive_incremental_pd.sv]
// top level of the differential drive incremental pd controller
//
// One control sample per clock: a sample is taken on every cycle in which the
// result side keeps up. Its result passes through the input register, product
// register, scaled term register and result register before it is presented
// on the output.
// The products for the left linear, right linear and angular terms are formed
// in parallel; the duty accumulators are updated in the last stage, where the
// add, 32 bit saturation, duty clamp and right-side mirror sit together,
// so each sample sees the accumulators left by the one before it. Stalls on
// the result side hold every stage; empty stages still fill. Configuration
// writes are taken in any cycle and must only be issued while the pipeline
// is empty.
module diff_drive_incremental_pd
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // target_linear, target_angular, left_velocity, right_velocity,
    // left_accel, right_accel, yaw_rate, yaw_accel (16 bits each, lowest first)
    input  logic [ddipd_pkg::S_TDATA_W-1:0]       s_tdata,
    // manual_mode
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // left_sum[31:0], right_sum[63:32], left_compare[79:64], right_compare[95:80]
    output logic [ddipd_pkg::M_TDATA_W-1:0]       m_tdata,
    // drive_valid
    output logic                                  m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ddipd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ddipd_pkg::DATA_W-1:0]          cfg_data
);

    localparam int DATA_W = ddipd_pkg::DATA_W;
    localparam int TERM_W = ddipd_pkg::TERM_W;

    ddipd_pkg::cfg_t    cfg;
    ddipd_pkg::pd_ctl_t pd_ctl;

    logic in_vld_reg;
    logic raw_vld_reg;
    logic term_vld_reg;
    logic out_vld_reg;
    logic in_vld_next;
    logic raw_vld_next;
    logic term_vld_next;
    logic out_vld_next;

    logic rdy_out;
    logic rdy_term;
    logic rdy_raw;
    logic accum_ld;

    logic [ddipd_pkg::S_TDATA_W-1:0] sample_reg;
    logic manual_in_reg;
    logic manual_raw_reg;
    logic manual_term_reg;

    logic signed [DATA_W-1:0] target_linear;
    logic signed [DATA_W-1:0] target_angular;
    logic signed [DATA_W-1:0] left_velocity;
    logic signed [DATA_W-1:0] right_velocity;
    logic signed [DATA_W-1:0] left_accel;
    logic signed [DATA_W-1:0] right_accel;
    logic signed [DATA_W-1:0] yaw_rate;
    logic signed [DATA_W-1:0] yaw_accel;

    logic signed [TERM_W-1:0] lin_l;
    logic signed [TERM_W-1:0] lin_r;
    logic signed [TERM_W-1:0] ang;

    logic signed [ddipd_pkg::DUTY_W-1:0] left_sum;
    logic signed [ddipd_pkg::DUTY_W-1:0] right_sum;
    logic [DATA_W-1:0]                   left_compare;
    logic [DATA_W-1:0]                   right_compare;
    logic                                drive_valid;

    assign cfg_ready = 1'b1;

    ddipd_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // a stage moves on when it is empty or the stage after it moves on
    assign rdy_out  = ~out_vld_reg | m_tready;
    assign rdy_term = ~term_vld_reg | rdy_out;
    assign rdy_raw  = ~raw_vld_reg | rdy_term;
    assign s_tready = ~in_vld_reg | rdy_raw;
    assign accum_ld = rdy_out & term_vld_reg;

    assign pd_ctl.ld_raw  = rdy_raw;
    assign pd_ctl.ld_term = rdy_term;

    assign in_vld_next   = s_tready ? s_tvalid     : in_vld_reg;
    assign raw_vld_next  = rdy_raw  ? in_vld_reg   : raw_vld_reg;
    assign term_vld_next = rdy_term ? raw_vld_reg  : term_vld_reg;
    assign out_vld_next  = rdy_out  ? term_vld_reg : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            raw_vld_reg  <= 1'b0;
            term_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            in_vld_reg   <= in_vld_next;
            raw_vld_reg  <= raw_vld_next;
            term_vld_reg <= term_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            sample_reg    <= s_tdata;
            manual_in_reg <= s_tuser;
        end
        if (rdy_raw)
        begin
            manual_raw_reg <= manual_in_reg;
        end
        if (rdy_term)
        begin
            manual_term_reg <= manual_raw_reg;
        end
    end

    assign target_linear  = sample_reg[0*DATA_W +: DATA_W];
    assign target_angular = sample_reg[1*DATA_W +: DATA_W];
    assign left_velocity  = sample_reg[2*DATA_W +: DATA_W];
    assign right_velocity = sample_reg[3*DATA_W +: DATA_W];
    assign left_accel     = sample_reg[4*DATA_W +: DATA_W];
    assign right_accel    = sample_reg[5*DATA_W +: DATA_W];
    assign yaw_rate       = sample_reg[6*DATA_W +: DATA_W];
    assign yaw_accel      = sample_reg[7*DATA_W +: DATA_W];

    ddipd_pd_term u_lin_l
    (
        .clk      (clk),
        .ctl      (pd_ctl),
        .kp       (cfg.kp_linear),
        .kd       (cfg.kd_linear),
        .target   (target_linear),
        .measured (left_velocity),
        .accel    (left_accel),
        .term     (lin_l)
    );

    ddipd_pd_term u_lin_r
    (
        .clk      (clk),
        .ctl      (pd_ctl),
        .kp       (cfg.kp_linear),
        .kd       (cfg.kd_linear),
        .target   (target_linear),
        .measured (right_velocity),
        .accel    (right_accel),
        .term     (lin_r)
    );

    ddipd_pd_term u_ang
    (
        .clk      (clk),
        .ctl      (pd_ctl),
        .kp       (cfg.kp_angular),
        .kd       (cfg.kd_angular),
        .target   (target_angular),
        .measured (yaw_rate),
        .accel    (yaw_accel),
        .term     (ang)
    );

    ddipd_accum u_accum
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .ld            (accum_ld),
        .lin_l         (lin_l),
        .lin_r         (lin_r),
        .ang           (ang),
        .manual        (manual_term_reg),
        .left_sum      (left_sum),
        .right_sum     (right_sum),
        .left_compare  (left_compare),
        .right_compare (right_compare),
        .drive_valid   (drive_valid)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {right_compare, left_compare, right_sum, left_sum};
    assign m_tuser  = drive_valid;

endmodule

[tb/diff_drive_incremental_pd_tb.sv]
// self-checking testbench for the differential drive incremental pd controller
module diff_drive_incremental_pd_tb;

    localparam int DATA_W    = ddipd_pkg::DATA_W;
    localparam int DUTY_W    = ddipd_pkg::DUTY_W;
    localparam int CFG_IDX_W = ddipd_pkg::CFG_IDX_W;
    localparam int S_TDATA_W = ddipd_pkg::S_TDATA_W;
    localparam int M_TDATA_W = ddipd_pkg::M_TDATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RUN_LIMIT = 2000000;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 105;

    // packed so that target_linear lands in the lowest bits, like s_tdata
    typedef struct packed {
        logic signed [DATA_W-1:0] yaw_accel;
        logic signed [DATA_W-1:0] yaw_rate;
        logic signed [DATA_W-1:0] right_accel;
        logic signed [DATA_W-1:0] left_accel;
        logic signed [DATA_W-1:0] right_velocity;
        logic signed [DATA_W-1:0] left_velocity;
        logic signed [DATA_W-1:0] target_angular;
        logic signed [DATA_W-1:0] target_linear;
    } ctrl_sample_t;

    // {m_tuser, m_tdata}
    typedef struct packed {
        logic                     drive_valid;
        logic [DATA_W-1:0]        right_compare;
        logic [DATA_W-1:0]        left_compare;
        logic signed [DUTY_W-1:0] right_sum;
        logic signed [DUTY_W-1:0] left_sum;
    } drive_result_t;

    class duty_tracker;
        logic signed [DATA_W-1:0] kp_lin, kd_lin, kp_ang, kd_ang;
        logic [DATA_W-1:0]        duty_hi, duty_lo, duty_mid;
        longint                   left_acc, right_acc;
        drive_result_t            pending_drive[$];
        int                       errors;

        function new();
            kp_lin    = ddipd_pkg::KP_LINEAR_RST;
            kd_lin    = ddipd_pkg::KD_LINEAR_RST;
            kp_ang    = ddipd_pkg::KP_ANGULAR_RST;
            kd_ang    = ddipd_pkg::KD_ANGULAR_RST;
            duty_hi   = ddipd_pkg::DUTY_MAX_RST;
            duty_lo   = ddipd_pkg::DUTY_MIN_RST;
            duty_mid  = ddipd_pkg::DUTY_NEUTRAL_RST;
            left_acc  = ddipd_pkg::DUTY_STATE_RST;
            right_acc = ddipd_pkg::DUTY_STATE_RST;
            errors    = 0;
        endfunction

        function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                ddipd_pkg::REG_KP_LINEAR:    kp_lin = value;
                ddipd_pkg::REG_KD_LINEAR:    kd_lin = value;
                ddipd_pkg::REG_KP_ANGULAR:   kp_ang = value;
                ddipd_pkg::REG_KD_ANGULAR:   kd_ang = value;
                ddipd_pkg::REG_DUTY_MAX:     duty_hi = value;
                ddipd_pkg::REG_DUTY_MIN:     duty_lo = value;
                ddipd_pkg::REG_DUTY_NEUTRAL: duty_mid = value;
                default: ;
            endcase
        endfunction

        // q16.16 product scaled back to counts, truncated toward zero
        function longint pd_count(longint kp, longint err, longint kd, longint acc);
            longint raw;
            raw = kp * err - kd * acc;
            return raw / 65536;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // max first, then min, so min above max gives min
        function longint clamp_duty(longint v);
            if (v > longint'(duty_hi))
                v = duty_hi;
            if (v < longint'(duty_lo))
                v = duty_lo;
            return v;
        endfunction

        function void take_sample(ctrl_sample_t smp, logic manual);
            longint        lin_l, lin_r, ang, cl, cr, mir;
            drive_result_t r;
            lin_l = pd_count(kp_lin, longint'(smp.target_linear) - longint'(smp.left_velocity),
                             kd_lin, smp.left_accel);
            lin_r = pd_count(kp_lin, longint'(smp.target_linear) - longint'(smp.right_velocity),
                             kd_lin, smp.right_accel);
            ang = pd_count(kp_ang, longint'(smp.target_angular) - longint'(smp.yaw_rate),
                           kd_ang, smp.yaw_accel);
            left_acc  = sat32(left_acc + lin_l - ang);
            right_acc = sat32(right_acc + lin_r + ang);
            r.left_sum  = left_acc[31:0];
            r.right_sum = right_acc[31:0];
            if (!manual)
            begin
                cl = clamp_duty(left_acc);
                cr = clamp_duty(right_acc);
                left_acc  = cl;
                right_acc = cr;
                mir = 2 * longint'(duty_mid) - cr;
                if (mir < 0)
                    mir = 0;
                if (mir > 65535)
                    mir = 65535;
                r.left_compare  = cl[15:0];
                r.right_compare = mir[15:0];
                r.drive_valid   = 1'b1;
            end
            else
            begin
                left_acc  = duty_mid;
                right_acc = duty_mid;
                r.left_compare  = '0;
                r.right_compare = '0;
                r.drive_valid   = 1'b0;
            end
            pending_drive.push_back(r);
        endfunction

        function void match_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_drive(drive_result_t got);
            drive_result_t want;
            if (pending_drive.size() == 0)
            begin
                $error("result transfer with nothing expected: %h", got);
                errors++;
                return;
            end
            want = pending_drive.pop_front();
            match_field("left_sum", want.left_sum, got.left_sum);
            match_field("right_sum", want.right_sum, got.right_sum);
            match_field("left_compare", {48'd0, want.left_compare}, {48'd0, got.left_compare});
            match_field("right_compare", {48'd0, want.right_compare},
                        {48'd0, got.right_compare});
            match_field("drive_valid", {63'd0, want.drive_valid}, {63'd0, got.drive_valid});
        endfunction

        function int pending();
            return pending_drive.size();
        endfunction

        function void flush_check();
            if (pending_drive.size() != 0)
            begin
                $error("%0d results never arrived", pending_drive.size());
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    duty_tracker tracker;
    bit          idle_on;
    int          rx_hold_left;
    int          rx_burst_left;

    diff_drive_incremental_pd dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #(RUN_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            tracker.take_sample(ctrl_sample_t'(s_tdata), s_tuser);
        if (rst_n && m_tvalid && m_tready)
            tracker.check_drive({m_tuser, m_tdata});
    end

    // result side: random stall bursts, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else if (rx_burst_left > 0)
            begin
                m_tready <= 1'b0;
                rx_burst_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    rx_burst_left = $urandom_range(1, 14);
            end
        end
    end

    function automatic ctrl_sample_t make_sample(int tl, int ta, int lv, int rv,
                                                 int la, int ra, int yr, int ya);
        ctrl_sample_t smp;
        smp.target_linear  = tl[15:0];
        smp.target_angular = ta[15:0];
        smp.left_velocity  = lv[15:0];
        smp.right_velocity = rv[15:0];
        smp.left_accel     = la[15:0];
        smp.right_accel    = ra[15:0];
        smp.yaw_rate       = yr[15:0];
        smp.yaw_accel      = ya[15:0];
        return smp;
    endfunction

    function automatic logic [DATA_W-1:0] rand_q88();
        case ($urandom_range(0, 5))
            0, 1:    return 16'($urandom());
            2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 1200) - 600);
        endcase
    endfunction

    function automatic ctrl_sample_t rand_sample();
        return make_sample(rand_q88(), rand_q88(), rand_q88(), rand_q88(),
                           rand_q88(), rand_q88(), rand_q88(), rand_q88());
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'd0;
            3:       return 16'($urandom_range(0, 1024));
            4:       return 16'(-$urandom_range(0, 1024));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.load_reg(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic feed(ctrl_sample_t smp, logic manual);
        if (idle_on && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 14))
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= manual;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop sending and let the pipeline empty out
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_phase(int ph);
        logic [DATA_W-1:0] lo, hi;
        write_reg(ddipd_pkg::REG_KP_LINEAR, pick_gain());
        write_reg(ddipd_pkg::REG_KD_LINEAR, pick_gain());
        write_reg(ddipd_pkg::REG_KP_ANGULAR, pick_gain());
        write_reg(ddipd_pkg::REG_KD_ANGULAR, pick_gain());
        lo = 16'($urandom_range(0, 30000));
        hi = 16'(lo + $urandom_range(0, 35000));
        case ($urandom_range(0, 4))
            0:
            begin
                lo = 16'd0;
                hi = 16'hffff;
            end
            1:
            begin
                // min above max
                hi = 16'($urandom_range(0, 20000));
                lo = 16'(hi + $urandom_range(1, 20000));
            end
            default: ;
        endcase
        write_reg(ddipd_pkg::REG_DUTY_MAX, hi);
        write_reg(ddipd_pkg::REG_DUTY_MIN, lo);
        case ($urandom_range(0, 3))
            0:       write_reg(ddipd_pkg::REG_DUTY_NEUTRAL, 16'd0);
            1:       write_reg(ddipd_pkg::REG_DUTY_NEUTRAL, 16'hffff);
            default: write_reg(ddipd_pkg::REG_DUTY_NEUTRAL, 16'($urandom()));
        endcase
        if (ph == 0)
            write_reg(REG_UNUSED, 16'($urandom()));
    endtask

    initial
    begin
        int wait_cycles;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = ddipd_pkg::REG_KP_LINEAR;
        cfg_data      = '0;
        idle_on       = 1'b1;
        rx_hold_left  = 0;
        rx_burst_left = 0;
        tracker       = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // reset gains: proportional gain 256 (1/256 after the 16 bit scale), no damping
        feed(make_sample(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        feed(make_sample(32767, 0, -32768, -32768, 0, 0, 0, 0), 1'b0);
        feed(make_sample(-32768, 0, 32767, 32767, 0, 0, 0, 0), 1'b0);
        feed(make_sample(0, 32767, 0, 0, 0, 0, -32768, 0), 1'b0);
        feed(make_sample(0, -32768, 0, 0, 0, 0, 32767, 0), 1'b0);
        // negative errors below one count truncate to zero
        feed(make_sample(0, 0, 1, 255, 0, 0, 0, 0), 1'b0);
        feed(make_sample(-1, 0, 256, 0, 0, 0, 0, -1), 1'b0);
        feed(make_sample(0, 0, 0, 0, 32767, -32768, 0, 32767), 1'b0);
        feed(make_sample(1234, -567, 100, -200, 5, -5, 9, -9), 1'b1);
        feed(make_sample(300, 200, 0, 0, 0, 0, 0, 0), 1'b0);
        drain();

        write_reg(ddipd_pkg::REG_KP_LINEAR, 16'h7fff);
        write_reg(ddipd_pkg::REG_KD_LINEAR, 16'h8000);
        write_reg(ddipd_pkg::REG_KP_ANGULAR, 16'h8000);
        write_reg(ddipd_pkg::REG_KD_ANGULAR, 16'h7fff);
        write_reg(ddipd_pkg::REG_DUTY_MAX, 16'hffff);
        write_reg(ddipd_pkg::REG_DUTY_MIN, 16'd0);
        write_reg(ddipd_pkg::REG_DUTY_NEUTRAL, 16'hffff);
        feed(make_sample(32767, 0, -32768, -32768, -32768, -32768, 0, 0), 1'b0);
        feed(make_sample(32767, 32767, -32768, -32768, -32768, -32768, -32768, -32768), 1'b0);
        feed(make_sample(-32768, 0, 32767, 32767, 32767, 32767, 0, 0), 1'b0);
        feed(make_sample(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767), 1'b0);
        feed(make_sample(100, -100, 50, 50, 0, 0, 0, 0), 1'b0);
        feed(make_sample(-32768, 32767, 32767, -32768, 32767, -32768, -32768, 32767), 1'b1);
        drain();

        // min above max, mirror below zero
        write_reg(ddipd_pkg::REG_DUTY_MAX, 16'd1000);
        write_reg(ddipd_pkg::REG_DUTY_MIN, 16'd3000);
        write_reg(ddipd_pkg::REG_DUTY_NEUTRAL, 16'd0);
        write_reg(ddipd_pkg::REG_KP_ANGULAR, 16'd0);
        feed(make_sample(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        feed(make_sample(32767, 100, -32768, 0, 0, 0, 0, 0), 1'b0);
        feed(make_sample(-32768, 0, 32767, 32767, 0, 0, 0, 0), 1'b1);
        feed(make_sample(5, 5, 5, 5, 5, 5, 5, 5), 1'b0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            program_phase(ph);
            idle_on = (ph != 2 && ph != PHASES - 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 1 && k == 30)
                    rx_hold_left = 90;
                if (ph == 3 && k == 50)
                    drain();
                feed(rand_sample(), $urandom_range(0, 11) == 0);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (tracker.pending() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (16) @(posedge clk);
        tracker.flush_check();
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
